// ----- sv/ball_bounce_physics_step_defines.svh -----
// Assertion macros for the ball step block
`ifndef BALL_BOUNCE_PHYSICS_STEP_DEFINES_SVH
`define BALL_BOUNCE_PHYSICS_STEP_DEFINES_SVH
// implication checked at every clock edge outside reset
`define BBPS_ASSERT_IMP(lbl, clk, rst, lhs, rhs) \
   lbl: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// next-cycle implication
`define BBPS_ASSERT_NXT(lbl, clk, rst, lhs, rhs) \
   lbl: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

// ----- sv/bbps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bbps_pkg
// Shared types and constants of the ball step block.
// ---------------------------------------------------------------------------
package bbps_pkg;
   localparam int BallMassDefault = 2;
   localparam int FracBitsDefault = 16;
   localparam int DataWidth = 32;
   localparam int DtWidth = 16;
   localparam int CsrAddrWidth = 5;
   // serial divider: dividend holds 7 times a 32-bit magnitude, divisor up to 127
   localparam int DvdWidth = 35;
   localparam int DvsWidth = 7;
   localparam int BounceDen = 10;

   typedef enum logic [1:0] {
      ACT_TICK = 2'd0,
      ACT_LAUNCH = 2'd1,
      ACT_PLACE = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_RADIUS = 3'd0,
      REG_LEFT = 3'd1,
      REG_RIGHT = 3'd2,
      REG_FLOOR = 3'd3,
      REG_CEIL = 3'd4,
      REG_GRAV = 3'd5,
      REG_FENCE_X = 3'd6,
      REG_FENCE_TOP = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [30:0] radius;
      logic signed [31:0] left_wall;
      logic signed [31:0] right_wall;
      logic signed [31:0] floor_level;
      logic signed [31:0] ceiling_level;
      logic signed [31:0] gravity_y;
      logic signed [31:0] fence_x;
      logic signed [31:0] fence_top;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic signed [31:0] mcand;
      logic [DtWidth-1:0] mplier;
   } mul_req_type;

   typedef struct packed {
      logic done;
      logic signed [47:0] product;
   } mul_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -36'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction
endpackage
`default_nettype wire

// ----- sv/bbps_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bbps_req_if
// Input channel: action, tick length and launch force.
// ---------------------------------------------------------------------------
interface bbps_req_if;
   import bbps_pkg::*;
   logic valid;
   logic ready;
   logic [1:0] action;
   logic [DtWidth-1:0] time_step;
   logic signed [31:0] push_x;
   logic signed [31:0] push_y;
   modport source(output valid, action, time_step, push_x, push_y, input ready);
   modport sink(input valid, action, time_step, push_x, push_y, output ready);
endinterface
`default_nettype wire

// ----- sv/bbps_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bbps_rsp_if
// Result channel: ball state after the step and fence hit flags.
// ---------------------------------------------------------------------------
interface bbps_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] pos_x_out;
   logic signed [31:0] pos_y_out;
   logic signed [31:0] vel_x_out;
   logic signed [31:0] vel_y_out;
   logic fence_side_hit;
   logic fence_top_hit;
   modport source(output valid, pos_x_out, pos_y_out, vel_x_out, vel_y_out,
      fence_side_hit, fence_top_hit, input ready);
   modport sink(input valid, pos_x_out, pos_y_out, vel_x_out, vel_y_out,
      fence_side_hit, fence_top_hit, output ready);
endinterface
`default_nettype wire

// ----- sv/ball_bounce_physics_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ball_bounce_physics_step
// One ball in a 2D room, stepped in signed fixed point.
// ---------------------------------------------------------------------------
// Usage: the req channel carries one item per step (tick, launch or place
// ball); the rsp channel returns one item with the ball state after it and
// the fence hit flags. Room geometry and gravity sit in APB registers;
// the user must write them only while the block is idle. The block itself
// does not enforce this. A tick runs three products of dt through a shared
// shift-add multiplier (one dt bit per cycle), then steps through the floor
// and ceiling, the side walls, friction, fence side, fence top and gravity.
// Each bounce (up to four per tick) runs 7|v| through a restoring divider
// by 10, one quotient bit per cycle. A launch runs force/BALL_MASS through
// the same divider for each axis. Place and the spare action code go
// straight to the output step.
// One item is in flight at a time; the result sits in an output register,
// and req is ready again the cycle after the receiver takes it, so a stall
// on rsp holds the block.
// Reset loads the register defaults, puts the ball at rest at
// (radius + left wall, radius) and empties the result register.
// ---------------------------------------------------------------------------
module ball_bounce_physics_step import bbps_pkg::*; #(
   parameter int BALL_MASS = BallMassDefault,
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   bbps_req_if.sink req,
   bbps_rsp_if.source rsp,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   typedef enum logic [3:0] {
      S_IDLE, S_MX, S_WX, S_MY, S_WY, S_MG, S_WG,
      S_WALLY, S_WALLX, S_FRIC, S_FENCE, S_TOP, S_GRAV, S_LY, S_DIV, S_OUT
   } state_type;

   localparam int DivCntWidth = $clog2(DvdWidth + 1);

   cfg_type cfg;
   mul_req_type mreq;
   mul_rsp_type mrsp;

   state_type state_ff;
   state_type ret_ff;
   logic signed [31:0] px_ff, py_ff, vx_ff, vy_ff;
   logic signed [31:0] px0_ff, py0_ff;
   logic signed [31:0] push_y_ff;
   logic [DtWidth-1:0] dt_ff;
   logic signed [47:0] gdt_ff;
   logic side_ff, top_ff;
   logic rsp_valid_ff;

   // restoring divider, shared by bounces and launches
   logic div_go_ff, div_busy_ff, div_done_ff;
   logic [DivCntWidth-1:0] div_cnt_ff;
   logic [DvdWidth-1:0] div_arg_ff, div_dq_ff;
   logic [DvsWidth-1:0] div_dvs_ff, div_rem_ff;
   logic div_neg_ff, div_vy_ff, div_add_ff;

   bbps_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   bbps_serial_mul u_mul (.clock, .reset, .req(mreq), .rsp(mrsp));

   // wide signed views
   logic signed [35:0] r, px, py, vx, vy, lw, rw, fl, cl, fx, fh, px0, py0;
   assign r = 36'(signed'({1'b0, cfg.radius}));
   assign px = 36'(px_ff);
   assign py = 36'(py_ff);
   assign vx = 36'(vx_ff);
   assign vy = 36'(vy_ff);
   assign lw = 36'(cfg.left_wall);
   assign rw = 36'(cfg.right_wall);
   assign fl = 36'(cfg.floor_level);
   assign cl = 36'(cfg.ceiling_level);
   assign fx = 36'(cfg.fence_x);
   assign fh = 36'(cfg.fence_top);
   assign px0 = 36'(px0_ff);
   assign py0 = 36'(py0_ff);

   logic signed [47:0] prod_sh, gdt_sh, fric;
   assign prod_sh = mrsp.product >>> FRAC_BITS;
   assign gdt_sh = gdt_ff >>> FRAC_BITS;
   assign fric = gdt_ff >>> (FRAC_BITS + 2);

   logic crossed, fence_ov;
   logic signed [35:0] fv;
   always_comb begin
      crossed = (px0 - r <= fx && px + r >= fx) || (px0 + r >= fx && px - r <= fx);
      fence_ov = side_ff || (px - r < fx && px + r > fx);
      fv = 36'(vx_ff);
      if (vx_ff > 0) fv = vx + 36'(fric);
      else if (vx_ff < 0) fv = vx - 36'(fric);
   end

   logic hit_floor, hit_ceil, hit_left, hit_right, hit_fence_l, hit_fence_r, hit_top;
   assign hit_floor = py - r < fl && vy_ff < 0;
   assign hit_ceil = py + r > cl && vy_ff > 0;
   assign hit_left = px - r < lw && vx_ff < 0;
   assign hit_right = px + r > rw && vx_ff > 0;
   assign hit_fence_l = py - r < fh && crossed && px0 + r <= fx && px + r > fx && vx_ff > 0;
   assign hit_fence_r = py - r < fh && crossed && px0 - r >= fx && px - r < fx && vx_ff < 0;
   assign hit_top = py - r < fh && py + r > fh && fence_ov && py0 - r >= fh && vy_ff < 0;

   logic take, bounce_y, bounce_go, launch_go;
   assign take = req.valid && req.ready;
   assign bounce_y = state_ff == S_WALLY || state_ff == S_TOP;
   assign bounce_go = (state_ff == S_WALLY && (hit_floor || hit_ceil)) ||
                      (state_ff == S_WALLX && (hit_left || hit_right)) ||
                      (state_ff == S_FENCE && (hit_fence_l || hit_fence_r)) ||
                      (state_ff == S_TOP && hit_top);
   assign launch_go = (take && action_type'(req.action) == ACT_LAUNCH) || state_ff == S_LY;

   // bounce dividend: 7|v| by shift and subtract
   logic signed [35:0] bv, babs, lv, labs;
   logic [DvdWidth-1:0] bmag;
   assign bv = bounce_y ? vy : vx;
   assign babs = bv < 0 ? -bv : bv;
   assign bmag = DvdWidth'((babs <<< 3) - babs);
   assign lv = state_ff == S_IDLE ? 36'(req.push_x) : 36'(push_y_ff);
   assign labs = lv < 0 ? -lv : lv;

   // quotient magnitude with the sign applied: rounds toward zero
   logic signed [35:0] dq_s, dval;
   assign dq_s = signed'(36'(div_dq_ff));
   assign dval = div_neg_ff ? -dq_s : dq_s;

   logic [DvsWidth:0] div_trial;
   logic div_fits;
   assign div_trial = {div_rem_ff, div_dq_ff[DvdWidth-1]};
   assign div_fits = div_trial >= {1'b0, div_dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_done_ff <= 1'b0;
         div_cnt_ff <= '0;
      end else begin
         div_done_ff <= 1'b0;
         if (div_go_ff) begin
            div_busy_ff <= 1'b1;
            div_cnt_ff <= DivCntWidth'(DvdWidth);
         end else if (div_busy_ff) begin
            div_cnt_ff <= div_cnt_ff - 1'b1;
            if (div_cnt_ff == DivCntWidth'(1)) begin
               div_busy_ff <= 1'b0;
               div_done_ff <= 1'b1;
            end
         end
      end
      // shift one dividend bit into the remainder, one quotient bit out
      if (div_go_ff) begin
         div_dq_ff <= div_arg_ff;
         div_rem_ff <= '0;
      end else if (div_busy_ff) begin
         div_dq_ff <= {div_dq_ff[DvdWidth-2:0], div_fits};
         div_rem_ff <= DvsWidth'(div_fits ? div_trial - {1'b0, div_dvs_ff} : div_trial);
      end
   end

   assign req.ready = state_ff == S_IDLE && !rsp_valid_ff;
   assign mreq.start = state_ff == S_MX || state_ff == S_MY || state_ff == S_MG;
   assign mreq.mplier = dt_ff;
   always_comb begin
      unique case (state_ff)
         S_MX: mreq.mcand = vx_ff;
         S_MY: mreq.mcand = vy_ff;
         default: mreq.mcand = cfg.gravity_y;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         div_go_ff <= 1'b0;
         px_ff <= sat32(36'sd32768);
         py_ff <= 32'sd32768;
         vx_ff <= '0;
         vy_ff <= '0;
         side_ff <= 1'b0;
         top_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (take) begin
               dt_ff <= req.time_step;
               px0_ff <= px_ff;
               py0_ff <= py_ff;
               side_ff <= 1'b0;
               top_ff <= 1'b0;
               unique case (action_type'(req.action))
                  ACT_TICK: state_ff <= S_MX;
                  ACT_LAUNCH: begin
                     push_y_ff <= req.push_y;
                     ret_ff <= S_LY;
                     state_ff <= S_DIV;
                  end
                  ACT_PLACE: begin
                     px_ff <= sat32(r + lw);
                     py_ff <= {1'b0, cfg.radius};
                     vx_ff <= '0;
                     vy_ff <= '0;
                     state_ff <= S_OUT;
                  end
                  default: state_ff <= S_OUT;
               endcase
            end
            S_MX: state_ff <= S_WX;
            S_WX: if (mrsp.done) begin
               px_ff <= sat32(px + 36'(prod_sh));
               state_ff <= S_MY;
            end
            S_MY: state_ff <= S_WY;
            S_WY: if (mrsp.done) begin
               py_ff <= sat32(py + 36'(prod_sh));
               state_ff <= S_MG;
            end
            S_MG: state_ff <= S_WG;
            S_WG: if (mrsp.done) begin
               gdt_ff <= mrsp.product;
               state_ff <= S_WALLY;
            end
            S_WALLY: begin
               if (hit_floor) py_ff <= sat32(r + fl);
               else if (hit_ceil) py_ff <= sat32(cl - r);
               ret_ff <= S_WALLX;
               state_ff <= bounce_go ? S_DIV : S_WALLX;
            end
            S_WALLX: begin
               if (hit_left) px_ff <= sat32(lw + r);
               else if (hit_right) px_ff <= sat32(rw - r);
               ret_ff <= S_FRIC;
               state_ff <= bounce_go ? S_DIV : S_FRIC;
            end
            S_FRIC: begin
               if (py - r <= fl) begin
                  if (vx_ff > 0) vx_ff <= fv < 0 ? 32'sd0 : sat32(fv);
                  else if (vx_ff < 0) vx_ff <= fv > 0 ? 32'sd0 : sat32(fv);
               end
               state_ff <= S_FENCE;
            end
            S_FENCE: begin
               if (hit_fence_l) begin
                  px_ff <= sat32(fx - r);
                  side_ff <= 1'b1;
               end else if (hit_fence_r) begin
                  px_ff <= sat32(fx + r);
                  side_ff <= 1'b1;
               end
               ret_ff <= S_TOP;
               state_ff <= bounce_go ? S_DIV : S_TOP;
            end
            S_TOP: begin
               if (hit_top) begin
                  py_ff <= sat32(fh + r);
                  top_ff <= 1'b1;
               end
               ret_ff <= S_GRAV;
               state_ff <= bounce_go ? S_DIV : S_GRAV;
            end
            S_GRAV: begin
               vy_ff <= sat32(vy + 36'(gdt_sh));
               state_ff <= S_OUT;
            end
            S_LY: begin
               ret_ff <= S_OUT;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               div_go_ff <= 1'b0;
               if (div_done_ff) begin
                  if (div_vy_ff) vy_ff <= sat32((div_add_ff ? vy : 36'sd0) + dval);
                  else vx_ff <= sat32((div_add_ff ? vx : 36'sd0) + dval);
                  state_ff <= ret_ff;
               end
            end
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         // load the divider: -7v/10 for a bounce, force/BALL_MASS for a launch
         if (bounce_go || launch_go) begin
            div_go_ff <= 1'b1;
            div_arg_ff <= bounce_go ? bmag : DvdWidth'(labs);
            div_dvs_ff <= bounce_go ? DvsWidth'(BounceDen) : DvsWidth'(BALL_MASS);
            div_neg_ff <= bounce_go ? bv > 0 : lv < 0;
            div_vy_ff <= bounce_y || state_ff == S_LY;
            div_add_ff <= !bounce_go;
         end
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.pos_x_out = px_ff;
   assign rsp.pos_y_out = py_ff;
   assign rsp.vel_x_out = vx_ff;
   assign rsp.vel_y_out = vy_ff;
   assign rsp.fence_side_hit = side_ff;
   assign rsp.fence_top_hit = top_ff;
endmodule
`default_nettype wire

// ----- sv/bbps_csr.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bbps_csr
// APB register file for the room geometry and gravity.
// ---------------------------------------------------------------------------
module bbps_csr import bbps_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready,
   output cfg_type cfg
);
   cfg_type cfg_ff;
   logic wr;
   reg_index_type idx;

   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign idx = reg_index_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius <= 31'd32768;
         cfg_ff.left_wall <= 32'sd0;
         cfg_ff.right_wall <= 32'sd655360;
         cfg_ff.floor_level <= 32'sd0;
         cfg_ff.ceiling_level <= 32'sd655360;
         cfg_ff.gravity_y <= -32'sd642253;
         cfg_ff.fence_x <= 32'sd327680;
         cfg_ff.fence_top <= 32'sd65536;
      end else if (wr) begin
         unique case (idx)
            REG_RADIUS: cfg_ff.radius <= csr_pwdata[30:0];
            REG_LEFT: cfg_ff.left_wall <= csr_pwdata;
            REG_RIGHT: cfg_ff.right_wall <= csr_pwdata;
            REG_FLOOR: cfg_ff.floor_level <= csr_pwdata;
            REG_CEIL: cfg_ff.ceiling_level <= csr_pwdata;
            REG_GRAV: cfg_ff.gravity_y <= csr_pwdata;
            REG_FENCE_X: cfg_ff.fence_x <= csr_pwdata;
            REG_FENCE_TOP: cfg_ff.fence_top <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (idx)
         REG_RADIUS: csr_prdata = {1'b0, cfg_ff.radius};
         REG_LEFT: csr_prdata = cfg_ff.left_wall;
         REG_RIGHT: csr_prdata = cfg_ff.right_wall;
         REG_FLOOR: csr_prdata = cfg_ff.floor_level;
         REG_CEIL: csr_prdata = cfg_ff.ceiling_level;
         REG_GRAV: csr_prdata = cfg_ff.gravity_y;
         REG_FENCE_X: csr_prdata = cfg_ff.fence_x;
         REG_FENCE_TOP: csr_prdata = cfg_ff.fence_top;
         default: csr_prdata = '0;
      endcase
   end
endmodule
`default_nettype wire

// ----- sv/bbps_serial_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bbps_serial_mul
// Shift-add multiplier: signed 32-bit value times unsigned dt, one dt bit
// per cycle.
// ---------------------------------------------------------------------------
module bbps_serial_mul import bbps_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);
   localparam int CntWidth = $clog2(DtWidth + 1);
   logic signed [47:0] acc_ff;
   logic signed [47:0] mcand_ff;
   logic [DtWidth-1:0] mplier_ff;
   logic [CntWidth-1:0] cnt_ff;
   logic busy_ff;
   logic done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= CntWidth'(DtWidth);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CntWidth'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      // payload: load, then add the shifted multiplicand for each set bit
      if (req.start) begin
         acc_ff <= '0;
         mcand_ff <= 48'(req.mcand);
         mplier_ff <= req.mplier;
      end else if (busy_ff) begin
         if (mplier_ff[0]) acc_ff <= acc_ff + mcand_ff;
         mcand_ff <= mcand_ff <<< 1;
         mplier_ff <= mplier_ff >> 1;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.product = acc_ff;
endmodule
`default_nettype wire

// ----- sv/bbps_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bbps_checker
// Port-level checks of the ball step block.
// ---------------------------------------------------------------------------
`include "ball_bounce_physics_step_defines.svh"
module bbps_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [31:0] rsp_pos_x,
   input wire logic side_hit,
   input wire logic top_hit
);
   `BBPS_ASSERT_IMP(no_take_while_full, clock, reset, rsp_valid, !req_ready)
   `BBPS_ASSERT_NXT(no_instant_result, clock, reset, req_valid && req_ready, !rsp_valid)
   `BBPS_ASSERT_NXT(rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_pos_x) && $stable(side_hit) && $stable(top_hit))
   `BBPS_ASSERT_IMP(ready_after_reset, clock, reset, $fell(reset), req_ready)
endmodule

bind ball_bounce_physics_step bbps_checker u_bbps_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_pos_x(rsp.pos_x_out),
   .side_hit(rsp.fence_side_hit), .top_hit(rsp.fence_top_hit)
);
`default_nettype wire
